// ===== rtl/ovhd_pkg.sv =====
// Shared constants, types and the likelihood table for the own-voice detector.
package ovhd_pkg;

  localparam int FEATURE_COUNT   = 4;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int TIME_BITS       = 48;

  localparam int FEAT_W   = 16;
  localparam int LK_W     = 16;
  localparam int IDX_W    = $clog2(EXP_TABLE_DEPTH);
  localparam int FI_W     = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int PROD_W   = 48;
  localparam int ACC_W    = PROD_W + 2;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W     = 192;
  localparam int IN_USER_W = 2;
  localparam int OUT_W    = 104;

  // health codes
  localparam logic [1:0] H_OK       = 2'd0;
  localparam logic [1:0] H_DISABLED = 2'd1;
  localparam logic [1:0] H_INVALID  = 2'd2;
  localparam logic [1:0] H_STALE    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] R_ENABLED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] R_ACT_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] R_REL_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] R_ACT_HOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] R_REL_HOLD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] R_STALE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] R_MEANS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] R_SCALES    = 3'd7;

  typedef logic [EXP_TABLE_DEPTH-1:0][LK_W-1:0] exp_tab_t;

  // result handed from the likelihood engine to the top level
  typedef struct packed {
    logic            done;
    logic [LK_W-1:0] lk;
  } ovhd_lik_res_t;

  // exp(-k*h) in Q1.15, h = 16 / depth, built from a Taylor step and repeated products
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] hq;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] t;
    hq   = 64'((64'd1 << 34) / EXP_TABLE_DEPTH);
    term = 64'd1 << 30;
    r    = 64'd1 << 30;
    t    = 64'd1 << 30;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * hq) / 64'(n)) >> 30;
      if (n[0]) r = r - term;
      else r = r + term;
    end
    tab[0] = 16'd32768;
    for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
      t = (t * r + (64'd1 << 29)) >> 30;
      tab[k] = 16'((t + (64'd1 << 14)) >> 15);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/own_voice_hysteresis_detector_unit.sv =====
// Own-voice detector top level: request checks, hysteresis holds, state and output register.
// Evaluate request: the checks, then the engine's square, scale and accumulate steps per feature, then its index
//   and table steps, then the hysteresis step and the output register.
// Time check and rejected requests: the checks, then the output register.
// One request at a time; in_tready is high only while the sequencer is idle.
// Synchronous active-low reset restores register defaults and state with health disabled.
module own_voice_hysteresis_detector_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // seq_number, observed_time, now_time, feature_0, feature_1, feature_2, feature_3
  input  logic [ovhd_pkg::IN_W-1:0]       in_tdata,
  // req_type, obs_valid
  input  logic [ovhd_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // voice_active, likelihood, health, generation, state_time, zero pad
  output logic [ovhd_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_we,
  input  logic [ovhd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ovhd_pkg::CFG_W-1:0]      cfg_wdata
);
  import ovhd_pkg::*;

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_CHECK = 3'd1;
  localparam logic [2:0] T_LIK   = 3'd2;
  localparam logic [2:0] T_HYST  = 3'd3;
  localparam logic [2:0] T_OUT   = 3'd4;

  // configuration
  logic                 en_r;
  logic [15:0]          act_lvl_r;
  logic [14:0]          rel_lvl_r;
  logic [TIME_BITS-1:0] act_hold_r, rel_hold_r, stale_r;
  logic [CFG_W-1:0]     means_r, scales_r;

  // latched request
  logic                 req_r, ovalid_r;
  logic [31:0]          seq_r;
  logic [TIME_BITS-1:0] obs_r, now_r;
  logic [FEATURE_COUNT*16-1:0] feat_r;

  // detector state
  logic [2:0]           fsm_r, fsm_nxt;
  logic                 active_r, active_nxt;
  logic [31:0]          gen_r, gen_nxt;
  logic [LK_W-1:0]      lk_r, lk_nxt;
  logic [TIME_BITS-1:0] stamp_r, stamp_nxt;
  logic [1:0]           health_r, health_nxt;
  logic                 seen_r, seen_nxt;
  logic [31:0]          prev_seq_r, prev_seq_nxt;
  logic [TIME_BITS-1:0] prev_stamp_r, prev_stamp_nxt;
  logic [TIME_BITS-1:0] rise_start_r, rise_start_nxt;
  logic                 rise_pend_r, rise_pend_nxt;
  logic [TIME_BITS-1:0] fall_start_r, fall_start_nxt;
  logic                 fall_pend_r, fall_pend_nxt;
  logic [LK_W-1:0]      lk_calc_r, lk_calc_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  logic                 in_fire;
  logic                 eng_start;
  ovhd_lik_res_t        eng_res;

  logic [TIME_BITS:0]   age_diff;
  logic                 age_neg, age_over, invalid;
  logic                 hold_on, pend_sel, hold_done;
  logic [TIME_BITS-1:0] start_sel, hold_sel;
  logic [TIME_BITS:0]   hold_diff;

  assign in_tready  = (fsm_r == T_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ovhd_lik_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (eng_start),
    .features (feat_r),
    .means    (means_r),
    .scales   (scales_r),
    .res      (eng_res)
  );

  // age against the observation (evaluate) or the stored stamp (time check)
  always_comb begin
    age_diff = {1'b0, now_r} - {1'b0, (req_r ? stamp_r : obs_r)};
    age_neg  = age_diff[TIME_BITS];
    age_over = age_diff[TIME_BITS-1:0] > stale_r;
    invalid  = !ovalid_r || age_neg ||
               (seen_r && ((seq_r <= prev_seq_r) || (obs_r < prev_stamp_r)));
  end

  // one hold timer compare serves whichever threshold is live
  always_comb begin
    hold_on   = active_r ? (lk_calc_r <= {1'b0, rel_lvl_r}) : (lk_calc_r >= act_lvl_r);
    pend_sel  = active_r ? fall_pend_r : rise_pend_r;
    start_sel = pend_sel ? (active_r ? fall_start_r : rise_start_r) : obs_r;
    hold_sel  = active_r ? rel_hold_r : act_hold_r;
    hold_diff = {1'b0, obs_r} - {1'b0, start_sel};
    hold_done = !hold_diff[TIME_BITS] && (hold_diff[TIME_BITS-1:0] >= hold_sel);
  end

  always_comb begin
    fsm_nxt        = fsm_r;
    active_nxt     = active_r;
    gen_nxt        = gen_r;
    lk_nxt         = lk_r;
    stamp_nxt      = stamp_r;
    health_nxt     = health_r;
    seen_nxt       = seen_r;
    prev_seq_nxt   = prev_seq_r;
    prev_stamp_nxt = prev_stamp_r;
    rise_start_nxt = rise_start_r;
    rise_pend_nxt  = rise_pend_r;
    fall_start_nxt = fall_start_r;
    fall_pend_nxt  = fall_pend_r;
    lk_calc_nxt    = lk_calc_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    eng_start      = 1'b0;

    unique case (fsm_r)
      T_IDLE: begin
        if (in_fire) fsm_nxt = T_CHECK;
      end
      T_CHECK: begin
        fsm_nxt = T_OUT;
        if (req_r) begin
          if (en_r && (health_r == H_OK) && (age_neg || age_over)) begin
            health_nxt = H_STALE;
          end
        end else if (!en_r) begin
          health_nxt = H_DISABLED;
        end else if (invalid) begin
          health_nxt = H_INVALID;
        end else if (age_over) begin
          health_nxt = H_STALE;
        end else begin
          eng_start = 1'b1;
          fsm_nxt   = T_LIK;
        end
        // unhealthy update; a time check keeps its stamp
        if (health_nxt != health_r || (!req_r && fsm_nxt == T_OUT)) begin
          gen_nxt        = gen_r + 32'd1;
          lk_nxt         = '0;
          stamp_nxt      = req_r ? stamp_r : obs_r;
          active_nxt     = 1'b0;
          rise_start_nxt = '0;
          rise_pend_nxt  = 1'b0;
          fall_start_nxt = '0;
          fall_pend_nxt  = 1'b0;
        end
      end
      T_LIK: begin
        if (eng_res.done) begin
          lk_calc_nxt = eng_res.lk;
          fsm_nxt     = T_HYST;
        end
      end
      T_HYST: begin
        if (!active_r) begin
          fall_start_nxt = '0;
          fall_pend_nxt  = 1'b0;
          if (hold_on && !hold_done) begin
            rise_start_nxt = start_sel;
            rise_pend_nxt  = 1'b1;
          end else begin
            rise_start_nxt = '0;
            rise_pend_nxt  = 1'b0;
            if (hold_on) active_nxt = 1'b1;
          end
        end else begin
          rise_start_nxt = '0;
          rise_pend_nxt  = 1'b0;
          if (hold_on && !hold_done) begin
            fall_start_nxt = start_sel;
            fall_pend_nxt  = 1'b1;
          end else begin
            fall_start_nxt = '0;
            fall_pend_nxt  = 1'b0;
            if (hold_on) active_nxt = 1'b0;
          end
        end
        seen_nxt       = 1'b1;
        prev_seq_nxt   = seq_r;
        prev_stamp_nxt = obs_r;
        gen_nxt        = gen_r + 32'd1;
        lk_nxt         = lk_calc_r;
        stamp_nxt      = obs_r;
        health_nxt     = H_OK;
        fsm_nxt        = T_OUT;
      end
      T_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, stamp_r, gen_r, health_r, lk_r, active_r};
          fsm_nxt       = T_IDLE;
        end
      end
      default: begin
        fsm_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r        <= T_IDLE;
      active_r     <= 1'b0;
      gen_r        <= '0;
      lk_r         <= '0;
      stamp_r      <= '0;
      health_r     <= H_DISABLED;
      seen_r       <= 1'b0;
      prev_seq_r   <= '0;
      prev_stamp_r <= '0;
      rise_start_r <= '0;
      rise_pend_r  <= 1'b0;
      fall_start_r <= '0;
      fall_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fsm_r        <= fsm_nxt;
      active_r     <= active_nxt;
      gen_r        <= gen_nxt;
      lk_r         <= lk_nxt;
      stamp_r      <= stamp_nxt;
      health_r     <= health_nxt;
      seen_r       <= seen_nxt;
      prev_seq_r   <= prev_seq_nxt;
      prev_stamp_r <= prev_stamp_nxt;
      rise_start_r <= rise_start_nxt;
      rise_pend_r  <= rise_pend_nxt;
      fall_start_r <= fall_start_nxt;
      fall_pend_r  <= fall_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lk_calc_r  <= lk_calc_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      req_r    <= in_tuser[0];
      ovalid_r <= in_tuser[1];
      seq_r    <= in_tdata[31:0];
      obs_r    <= in_tdata[79:32];
      now_r    <= in_tdata[127:80];
      feat_r   <= in_tdata[128 +: FEATURE_COUNT*16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r       <= 1'b0;
      act_lvl_r  <= 16'd32768;
      rel_lvl_r  <= '0;
      act_hold_r <= TIME_BITS'(1);
      rel_hold_r <= TIME_BITS'(1);
      stale_r    <= TIME_BITS'(1);
      means_r    <= '0;
      scales_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        R_ENABLED:   en_r       <= cfg_wdata[0];
        R_ACT_LEVEL: act_lvl_r  <= cfg_wdata[15:0];
        R_REL_LEVEL: rel_lvl_r  <= cfg_wdata[14:0];
        R_ACT_HOLD:  act_hold_r <= cfg_wdata[TIME_BITS-1:0];
        R_REL_HOLD:  rel_hold_r <= cfg_wdata[TIME_BITS-1:0];
        R_STALE:     stale_r    <= cfg_wdata[TIME_BITS-1:0];
        R_MEANS:     means_r    <= cfg_wdata;
        R_SCALES:    scales_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ovhd_lik_engine.sv =====
// Sequenced likelihood engine: weighted squared distance on one shared multiplier, then table.
module ovhd_lik_engine (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [ovhd_pkg::FEATURE_COUNT*16-1:0]       features,
  input  logic [ovhd_pkg::CFG_W-1:0]                  means,
  input  logic [ovhd_pkg::CFG_W-1:0]                  scales,
  output ovhd_pkg::ovhd_lik_res_t                     res
);
  import ovhd_pkg::*;

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_SQ   = 3'd1;
  localparam logic [2:0] E_SC   = 3'd2;
  localparam logic [2:0] E_ACC  = 3'd3;
  localparam logic [2:0] E_IDX  = 3'd4;
  localparam logic [2:0] E_LK   = 3'd5;

  localparam logic [15:0] DEPTH16 = 16'(EXP_TABLE_DEPTH);

  logic [2:0]        state_r, state_nxt;
  logic [FI_W-1:0]   fi_r, fi_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  logic [15:0]       mul_a;
  logic [31:0]       mul_b;
  logic signed [16:0] delta;
  logic [15:0]       mag;
  logic [15:0]       sc;
  logic              any_used;
  logic [LK_W-1:0]   lk;

  always_comb begin
    delta = $signed({features[16*fi_r + 15], features[16*fi_r +: 16]})
          - $signed({means[16*fi_r + 15], means[16*fi_r +: 16]});
    mag   = delta[16] ? 16'(-delta) : delta[15:0];
    sc    = scales[16*fi_r +: 16];
  end

  always_comb begin
    any_used = 1'b0;
    for (int i = 0; i < FEATURE_COUNT; i++) begin
      if (scales[16*i +: 16] != 16'd0) any_used = 1'b1;
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      E_SQ: begin
        mul_a = mag;
        mul_b = {16'd0, mag};
      end
      E_SC: begin
        mul_a = sc;
        mul_b = prod_r[31:0];
      end
      E_IDX: begin
        mul_a = DEPTH16;
        mul_b = {16'd0, acc_r[15:0]};
      end
      default: begin
        mul_a = 16'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    fi_nxt    = fi_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    unique case (state_r)
      E_IDLE: begin
        if (start) begin
          fi_nxt    = '0;
          acc_nxt   = '0;
          state_nxt = E_SQ;
        end
      end
      E_SQ: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = E_SC;
      end
      E_SC: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = E_ACC;
      end
      E_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_r);
        if (fi_r == FI_W'(FEATURE_COUNT - 1)) begin
          state_nxt = E_IDX;
        end else begin
          fi_nxt    = fi_r + 1'b1;
          state_nxt = E_SQ;
        end
      end
      E_IDX: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = E_LK;
      end
      E_LK: begin
        state_nxt = E_IDLE;
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fi_r   <= fi_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  // distance at or beyond 16.0 falls off the table
  always_comb begin
    if (!any_used || (acc_r[ACC_W-1:16] != '0)) lk = '0;
    else lk = EXP_TAB[prod_r[16 +: IDX_W]];
  end

  assign res.done = (state_r == E_LK);
  assign res.lk   = lk;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the own-voice hysteresis detector top level.
`timescale 1ns / 1ps

module tb;
  import ovhd_pkg::*;

  localparam logic REQ_EVAL       = 1'b0;
  localparam logic REQ_TIME_CHECK = 1'b1;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic              rtype;
    logic              ovalid;
    logic [31:0]       seq;
    logic [47:0]       obs;
    logic [47:0]       now;
    logic [3:0][15:0]  feat;
  } request_t;

  typedef struct packed {
    logic        active;
    logic [15:0] lk;
    logic [1:0]  health;
    logic [31:0] gen;
    logic [47:0] stamp;
  } status_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          val;
    request_t             req;
    bit                   typed;
    status_t              want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // seq_number, observed_time, now_time, feature_0..feature_3 (lowest bit up)
  logic [IN_W-1:0]       in_tdata = '0;
  // req_type, obs_valid (lowest bit up)
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // voice_active, likelihood, health, generation, state_time, zero pad (lowest bit up)
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  own_voice_hysteresis_detector_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // register copies
  logic        en_r;
  logic [15:0] act_lvl_r;
  logic [14:0] rel_lvl_r;
  logic [47:0] act_hold_r, rel_hold_r, stale_r;
  logic [63:0] means_r, scales_r;

  // detector state as predicted
  logic        voice_on, any_seen, rise_armed, fall_armed;
  logic [31:0] gen_count, last_seq;
  logic [15:0] lk_last;
  logic [1:0]  health_now;
  logic [47:0] stamp_now, last_obs, rise_t0, fall_t0;

  logic [15:0] lk_tab [EXP_TABLE_DEPTH];
  status_t     pending_status [$];
  dir_row_t    dir_rows [$];

  int  errors = 0;
  int  n_requests = 0;
  int  n_checked = 0;
  int  n_rises = 0;
  int  health_seen [4] = '{0, 0, 0, 0};
  bit  calm = 1'b0;
  int  step_cap = 4;
  int  spread = 8;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
    errors++;
    if (errors <= 25)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp_v);
  endtask

  // exp(-k*16/depth) in Q1.15 from a truncated series and repeated products
  function automatic void build_lk_table();
    longint unsigned step_q, term, ratio, acc;
    step_q = (64'd1 << 34) / EXP_TABLE_DEPTH;
    term   = 64'd1 << 30;
    ratio  = 64'd1 << 30;
    acc    = 64'd1 << 30;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * step_q) / n) >> 30;
      if (n % 2 == 1) ratio = ratio - term;
      else ratio = ratio + term;
    end
    lk_tab[0] = 16'd32768;
    for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
      acc = (acc * ratio + (64'd1 << 29)) >> 30;
      lk_tab[k] = 16'((acc + (64'd1 << 14)) >> 15);
    end
  endfunction

  function automatic logic [15:0] likelihood_of_features(input logic [3:0][15:0] feat);
    longint unsigned dist_sum, idx, sc, mag;
    bit any;
    int fv, mv, dv;
    dist_sum = 0;
    any  = 1'b0;
    for (int i = 0; i < FEATURE_COUNT; i++) begin
      sc = scales_r[16*i +: 16];
      fv = $signed(feat[i]);
      mv = $signed(means_r[16*i +: 16]);
      dv = fv - mv;
      mag = (dv < 0) ? -dv : dv;
      if (sc != 0) begin
        any = 1'b1;
        dist_sum += sc * mag * mag;
      end
    end
    if (!any) return 16'd0;
    idx = (dist_sum * EXP_TABLE_DEPTH) >> 16;
    return (idx < EXP_TABLE_DEPTH) ? lk_tab[idx] : 16'd0;
  endfunction

  function automatic bit hold_met(input logic [47:0] obs, input logic [47:0] start,
                                  input logic [47:0] dur);
    return obs >= start && (obs - start) >= dur;
  endfunction

  function automatic void mark_unhealthy(input logic [1:0] code, input logic [47:0] stamp);
    gen_count++;
    lk_last    = '0;
    stamp_now  = stamp;
    voice_on   = 1'b0;
    health_now = code;
    rise_t0    = '0;
    rise_armed = 1'b0;
    fall_t0    = '0;
    fall_armed = 1'b0;
  endfunction

  function automatic status_t predict_request(input request_t r);
    logic [15:0] lk;
    if (r.rtype == REQ_TIME_CHECK) begin
      if (en_r && health_now == H_OK && !(r.now >= stamp_now && r.now - stamp_now <= stale_r))
        mark_unhealthy(H_STALE, stamp_now);
    end else if (!en_r) begin
      mark_unhealthy(H_DISABLED, r.obs);
    end else if (!r.ovalid || r.now < r.obs ||
                 (any_seen && (r.seq <= last_seq || r.obs < last_obs))) begin
      mark_unhealthy(H_INVALID, r.obs);
    end else if (r.now - r.obs > stale_r) begin
      mark_unhealthy(H_STALE, r.obs);
    end else begin
      lk = likelihood_of_features(r.feat);
      if (!voice_on) begin
        fall_t0    = '0;
        fall_armed = 1'b0;
        if (lk >= act_lvl_r) begin
          if (!rise_armed) begin
            rise_t0    = r.obs;
            rise_armed = 1'b1;
          end
          if (hold_met(r.obs, rise_t0, act_hold_r)) begin
            voice_on   = 1'b1;
            rise_t0    = '0;
            rise_armed = 1'b0;
            n_rises++;
          end
        end else begin
          rise_t0    = '0;
          rise_armed = 1'b0;
        end
      end else begin
        rise_t0    = '0;
        rise_armed = 1'b0;
        if (lk <= rel_lvl_r) begin
          if (!fall_armed) begin
            fall_t0    = r.obs;
            fall_armed = 1'b1;
          end
          if (hold_met(r.obs, fall_t0, rel_hold_r)) begin
            voice_on   = 1'b0;
            fall_t0    = '0;
            fall_armed = 1'b0;
          end
        end else begin
          fall_t0    = '0;
          fall_armed = 1'b0;
        end
      end
      any_seen   = 1'b1;
      last_seq   = r.seq;
      last_obs   = r.obs;
      gen_count++;
      lk_last    = lk;
      stamp_now  = r.obs;
      health_now = H_OK;
    end
    health_seen[health_now]++;
    return '{voice_on, lk_last, health_now, gen_count, stamp_now};
  endfunction

  function automatic status_t want_st(input logic a, input logic [15:0] lk, input logic [1:0] h,
                                      input logic [31:0] g, input logic [47:0] s);
    return '{a, lk, h, g, s};
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  function automatic dir_row_t req_row(input logic rtype, input logic ovalid,
                                       input logic [31:0] seq, input logic [47:0] obs,
                                       input logic [47:0] now, input logic [15:0] feat,
                                       input bit typed, input status_t want);
    dir_row_t row;
    row = '{default: '0};
    row.req.rtype  = rtype;
    row.req.ovalid = ovalid;
    row.req.seq    = seq;
    row.req.obs    = obs;
    row.req.now    = now;
    row.req.feat   = {4{feat}};
    row.typed      = typed;
    row.want       = want;
    return row;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      R_ENABLED:   en_r       = val[0];
      R_ACT_LEVEL: act_lvl_r  = val[15:0];
      R_REL_LEVEL: rel_lvl_r  = val[14:0];
      R_ACT_HOLD:  act_hold_r = val[47:0];
      R_REL_HOLD:  rel_hold_r = val[47:0];
      R_STALE:     stale_r    = val[47:0];
      R_MEANS:     means_r    = val;
      R_SCALES:    scales_r   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // always waits on the clock before checking, so the next drive lands in a fresh step
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic send_request(input request_t r, input bit typed, input status_t want);
    status_t predicted;
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 13) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.feat, r.now, r.obs, r.seq};
    in_tuser  <= {r.ovalid, r.rtype};
    do @(posedge clk); while (!in_tready);
    predicted = predict_request(r);
    pending_status.push_back(typed ? want : predicted);
    n_requests++;
  endtask

  function automatic logic [47:0] pick_hold();
    case ($urandom_range(0, 3))
      0:       return 48'd1;
      1:       return TIME_MAX;
      default: return 48'($urandom_range(2, 200));
    endcase
  endfunction

  task automatic program_phase(input int p);
    logic [63:0] scales;
    logic [47:0] tmo;
    wait_drained();
    for (int k = 0; k < 4; k++)
      scales[16*k +: 16] = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 15));
    case ($urandom_range(0, 3))
      0:       tmo = 48'd1;
      1:       tmo = TIME_MAX;
      default: tmo = 48'($urandom_range(2, 400));
    endcase
    if (p == 1) scales = '1;
    if (p == 2) scales = '0;
    write_reg(R_ENABLED, (p == 3) ? 64'd0 : 64'd1);
    case ($urandom_range(0, 2))
      0:       write_reg(R_ACT_LEVEL, 64'd1);
      1:       write_reg(R_ACT_LEVEL, 64'd32768);
      default: write_reg(R_ACT_LEVEL, 64'($urandom_range(1, 32768)));
    endcase
    case ($urandom_range(0, 2))
      0:       write_reg(R_REL_LEVEL, 64'd0);
      1:       write_reg(R_REL_LEVEL, 64'd32767);
      default: write_reg(R_REL_LEVEL, 64'($urandom_range(0, 32767)));
    endcase
    write_reg(R_ACT_HOLD, (p == 1) ? 64'(TIME_MAX) : 64'(pick_hold()));
    write_reg(R_REL_HOLD, (p == 1) ? 64'(TIME_MAX) : 64'(pick_hold()));
    write_reg(R_STALE, (p == 1) ? 64'(TIME_MAX) : 64'(tmo));
    write_reg(R_MEANS, (p == 1) ? 64'h8000_7FFF_0000_FFFF : {$urandom, $urandom});
    write_reg(R_SCALES, scales);
    cfg_we <= 1'b0;
    case ($urandom_range(0, 3))
      0:       step_cap = 1;
      1:       step_cap = 4;
      2:       step_cap = 50;
      default: step_cap = 300;
    endcase
    case ($urandom_range(0, 3))
      0:       spread = 0;
      1:       spread = 8;
      2:       spread = 40;
      default: spread = 120;
    endcase
  endtask

  // mostly in-order observations with random content, plus noise and broken ones
  function automatic request_t gen_request();
    request_t r;
    logic [47:0] lag;
    int sel, d;
    r.rtype  = REQ_EVAL;
    r.ovalid = 1'b1;
    r.seq    = last_seq + $urandom_range(1, 3);
    r.obs    = last_obs + $urandom_range(0, step_cap);
    if ($urandom_range(0, 9) == 0) lag = stale_r;
    else lag = $urandom_range(0, (stale_r < 200) ? int'(stale_r) : 200);
    r.now = r.obs + lag;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        r.feat[k] = 16'($urandom);
      end else begin
        d = $urandom_range(0, 2 * spread) - spread;
        r.feat[k] = means_r[16*k +: 16] + 16'(d);
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      r.rtype = REQ_TIME_CHECK;
      r.seq   = $urandom;
      r.obs   = {$urandom, $urandom};
      r.now   = (sel == 0) ? stamp_now - 48'd1 : stamp_now + lag;
    end else if (sel < 14) begin
      r.ovalid = 1'b0;
      r.seq    = $urandom;
      r.obs    = {$urandom, $urandom};
      r.now    = {$urandom, $urandom};
    end else if (sel < 16) begin
      r.seq = last_seq;
    end else if (sel < 18) begin
      if (last_obs != 0) begin
        r.obs = last_obs - 48'd1;
        r.now = r.obs + lag;
      end
    end else if (sel < 20) begin
      r.now = r.obs - 48'd1;
    end else if (sel < 23) begin
      r.now = r.obs + stale_r + 48'd1;
    end
    return r;
  endfunction

  always @(posedge clk)
    out_tready <= calm || ($urandom_range(0, 99) >= 13);

  always @(posedge clk) begin : result_check
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        report("result with nothing pending", out_tdata[63:0], '0);
      end else begin
        want = pending_status.pop_front();
        n_checked++;
        if (out_tdata[0] !== want.active)
          report("voice_active", out_tdata[0], want.active);
        if (out_tdata[16:1] !== want.lk)
          report("likelihood", out_tdata[16:1], want.lk);
        if (out_tdata[18:17] !== want.health)
          report("health", out_tdata[18:17], want.health);
        if (out_tdata[50:19] !== want.gen)
          report("generation", out_tdata[50:19], want.gen);
        if (out_tdata[98:51] !== want.stamp)
          report("state_time", out_tdata[98:51], want.stamp);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** own_voice_hysteresis_detector_unit: FAILED **");
    $finish;
  end

  initial begin
    request_t r;
    int n_items;
    build_lk_table();
    en_r = 1'b0; act_lvl_r = 16'd32768; rel_lvl_r = '0;
    act_hold_r = 48'd1; rel_hold_r = 48'd1; stale_r = 48'd1;
    means_r = '0; scales_r = '0;
    voice_on = 1'b0; any_seen = 1'b0; rise_armed = 1'b0; fall_armed = 1'b0;
    gen_count = '0; last_seq = '0; lk_last = '0; health_now = H_DISABLED;
    stamp_now = '0; last_obs = '0; rise_t0 = '0; fall_t0 = '0;

    // after reset, disabled, no features, holds, invalid kinds, stale, time checks
    dir_rows.push_back(req_row(REQ_TIME_CHECK, 1, 0, 0, 0, 16'h0, 1,
                               want_st(0, 0, H_DISABLED, 0, 0)));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 1, 48'h123, 48'h200, 16'h0, 1,
                               want_st(0, 0, H_DISABLED, 1, 48'h123)));
    dir_rows.push_back(cfg_row(R_ENABLED, 64'd1));
    dir_rows.push_back(cfg_row(R_STALE, 64'(TIME_MAX)));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 1, 100, 100, 16'h0, 1,
                               want_st(0, 0, H_OK, 2, 100)));
    dir_rows.push_back(cfg_row(R_SCALES, 64'h0001_0001_0001_0001));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 2, 200, 200, 16'h0, 1,
                               want_st(0, 16'd32768, H_OK, 3, 200)));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 3, 201, 201, 16'h0, 1,
                               want_st(1, 16'd32768, H_OK, 4, 201)));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 4, 300, 300, 16'h8000, 1,
                               want_st(1, 0, H_OK, 5, 300)));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 5, 301, 301, 16'h7FFF, 1,
                               want_st(0, 0, H_OK, 6, 301)));
    dir_rows.push_back(req_row(REQ_EVAL, 0, 6, 400, 400, 16'h0, 1,
                               want_st(0, 0, H_INVALID, 7, 400)));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 5, 500, 500, 16'h0, 1,
                               want_st(0, 0, H_INVALID, 8, 500)));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 6, 300, 300, 16'h0, 1,
                               want_st(0, 0, H_INVALID, 9, 300)));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 6, 600, 599, 16'h0, 1,
                               want_st(0, 0, H_INVALID, 10, 600)));
    dir_rows.push_back(cfg_row(R_STALE, 64'd1));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 6, 700, 702, 16'h0, 1,
                               want_st(0, 0, H_STALE, 11, 700)));
    dir_rows.push_back(req_row(REQ_TIME_CHECK, 1, 0, 0, 702, 16'h0, 1,
                               want_st(0, 0, H_STALE, 11, 700)));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 7, 800, 801, 16'h0, 1,
                               want_st(0, 16'd32768, H_OK, 12, 800)));
    dir_rows.push_back(req_row(REQ_TIME_CHECK, 1, 0, 0, 801, 16'h0, 1,
                               want_st(0, 16'd32768, H_OK, 12, 800)));
    dir_rows.push_back(req_row(REQ_TIME_CHECK, 1, 0, 0, 799, 16'h0, 1,
                               want_st(0, 0, H_STALE, 13, 800)));
    dir_rows.push_back(cfg_row(R_MEANS, 64'h0010_0010_0010_0010));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 8, 900, 900, 16'h0074, 0, '0));
    dir_rows.push_back(req_row(REQ_EVAL, 1, 9, 901, 901, 16'hFFB6, 0, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        cfg_we <= 1'b0;
        send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      program_phase(p);
      calm = (p == 5);
      n_items = (p == 3) ? 30 : 145;
      for (int i = 0; i < n_items; i++) begin
        send_request(gen_request(), 1'b0, '0);
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
      calm = 1'b0;
    end

    // largest sequence number and time stamps last: nothing in order can follow them
    r = gen_request();
    r.rtype  = REQ_EVAL;
    r.ovalid = 1'b1;
    r.seq    = '1;
    r.obs    = TIME_MAX - 48'd1;
    r.now    = TIME_MAX;
    send_request(r, 1'b0, '0);
    r.rtype = REQ_TIME_CHECK;
    send_request(r, 1'b0, '0);

    in_tvalid <= 1'b0;
    for (int k = 0; k < 5000 && pending_status.size() != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_status.size() != 0)
      report("results never returned", pending_status.size(), 0);

    $display("%0d requests sent, %0d results checked, %0d activations", n_requests, n_checked,
             n_rises);
    $display("health after request: ok %0d, disabled %0d, invalid %0d, stale %0d",
             health_seen[H_OK], health_seen[H_DISABLED], health_seen[H_INVALID],
             health_seen[H_STALE]);
    if (errors == 0)
      $display("** own_voice_hysteresis_detector_unit: PASSED **");
    else
      $display("** own_voice_hysteresis_detector_unit: FAILED **");
    $finish;
  end

endmodule
